### hw/rtl/pqtt_pkg.sv
package pqtt_pkg;

  // Fixed field widths.
  localparam int PITCH_W    = 24;
  localparam int CHAN_W     = 4;
  localparam int NOTE_IDX_W = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 2;
  localparam int RND_W      = 2;

  // Default configuration of the block.
  localparam int NOTE_COUNT_DEF      = 128;
  localparam int CHANNEL_COUNT_DEF   = 16;
  localparam int PITCH_FRAC_BITS_DEF = 16;

  // Saturation limits of a pitch value.
  localparam longint PITCH_MAX = (longint'(1) <<< (PITCH_W - 1)) - 1;
  localparam longint PITCH_MIN = -(longint'(1) <<< (PITCH_W - 1));

  // Request opcodes.
  localparam logic OP_QUANT = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Mode register codes.
  localparam logic MODE_RETUNE = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  // Rounding register codes; the unused code behaves as nearest.
  localparam logic [RND_W-1:0] RND_DOWN = 2'd0;
  localparam logic [RND_W-1:0] RND_NEAR = 2'd1;
  localparam logic [RND_W-1:0] RND_UP   = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_QUANT_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROUNDING    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_VALID = 2'd2;

  // Control handed from the sequencer to the search unit.
  typedef struct packed {
    logic clear;
    logic step;
  } scan_ctl_t;

  // Equal-tempered pitch of note n: (n-60)/12 volts, rounded half away from zero,
  // saturated to the pitch width.
  function automatic logic signed [PITCH_W-1:0] et_pitch(input int n, input int frac);
    longint v;
    longint q;
    v = longint'(n - 60) * (longint'(1) <<< frac);
    if (v >= 0) begin
      q = (v + 6) / 12;
    end else begin
      q = -((-v + 6) / 12);
    end
    if (q > PITCH_MAX) begin
      q = PITCH_MAX;
    end else if (q < PITCH_MIN) begin
      q = PITCH_MIN;
    end
    return PITCH_W'(q);
  endfunction

endpackage

### hw/rtl/pqtt_cell.sv
module pqtt_cell
  import pqtt_pkg::*;
#(
  parameter logic signed [PITCH_W-1:0] RESET_PITCH = '0
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  logic signed [PITCH_W-1:0] wr_pitch,
  input  logic                      wr_filt,
  input  logic                      shift,
  input  logic signed [PITCH_W-1:0] nb_pitch,
  input  logic                      nb_filt,
  output logic signed [PITCH_W-1:0] pitch,
  output logic                      filt
);

  // One table entry: loaded by a table write, or taken from the neighbor during a scan.
  always_ff @(posedge clk) begin
    if (rst) begin
      pitch <= RESET_PITCH;
      filt  <= 1'b0;
    end else if (wr_en) begin
      pitch <= wr_pitch;
      filt  <= wr_filt;
    end else if (shift) begin
      pitch <= nb_pitch;
      filt  <= nb_filt;
    end
  end

endmodule

### hw/rtl/pqtt_search.sv
module pqtt_search
  import pqtt_pkg::*;
#(
  parameter int NOTE_COUNT = NOTE_COUNT_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  scan_ctl_t                            ctl,
  input  logic [$clog2(NOTE_COUNT)-1:0]        idx,
  input  logic [$clog2(NOTE_COUNT)-1:0]        sel,
  input  logic signed [PITCH_W-1:0]            p,
  input  logic signed [PITCH_W-1:0]            t,
  input  logic                                 t_filt,
  input  logic                                 mode,
  input  logic [RND_W-1:0]                     rounding,
  output logic signed [PITCH_W-1:0]            res
);

  localparam int IDX_W = $clog2(NOTE_COUNT);

  logic                      have_lo;
  logic                      have_hi;
  logic                      exact;
  logic signed [PITCH_W-1:0] lo;
  logic signed [PITCH_W-1:0] hi;
  logic signed [PITCH_W-1:0] e0;
  logic signed [PITCH_W-1:0] rt;
  logic signed [PITCH_W:0]   mid_sum;
  logic signed [PITCH_W:0]   p2;
  logic signed [PITCH_W-1:0] found;

  // Track the nearest unfiltered note strictly below and above the sample.
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      have_lo <= 1'b0;
      have_hi <= 1'b0;
      exact   <= 1'b0;
    end else if (ctl.step && !t_filt) begin
      if (t == p) begin
        exact <= 1'b1;
      end else if (t < p) begin
        if (!have_lo || t > lo) begin
          have_lo <= 1'b1;
        end
      end else begin
        if (!have_hi || t < hi) begin
          have_hi <= 1'b1;
        end
      end
    end
  end

  // Payload of the scan: bounds, entry zero and the retune entry.
  always_ff @(posedge clk) begin
    if (ctl.step) begin
      if (!t_filt && t < p && (!have_lo || t > lo)) begin
        lo <= t;
      end
      if (!t_filt && t > p && (!have_hi || t < hi)) begin
        hi <= t;
      end
      if (idx == IDX_W'(0)) begin
        e0 <= t;
      end
      if (idx == sel) begin
        rt <= t;
      end
    end
  end

  // Pick the result once the whole table has gone by.
  assign mid_sum = {lo[PITCH_W-1], lo} + {hi[PITCH_W-1], hi};
  assign p2      = {p, 1'b0};

  always_comb begin
    priority if (exact) begin
      found = p;
    end else if (!have_lo && !have_hi) begin
      found = e0;
    end else if (!have_lo) begin
      found = hi;
    end else if (!have_hi) begin
      found = lo;
    end else if (rounding == RND_DOWN) begin
      found = lo;
    end else if (rounding == RND_UP) begin
      found = hi;
    end else if (p2 < mid_sum) begin
      found = lo;
    end else begin
      found = hi;
    end
  end

  assign res = (mode == MODE_SEARCH) ? found : rt;

endmodule

### hw/rtl/pitch_quantizer_to_tuning_table_top.sv
// Timing: a table write is accepted while the sequencer is idle. A quantize request with a
// valid table scans the ring of note cells, one entry per cycle, then loads the output
// register from the finishing state. No new request is accepted until that result is loaded;
// a pass-through request skips the scan and goes straight to the finishing state. A stalled
// result holds the input.
// Reset: table cells load equal temperament, filters and per-channel history clear.
module pitch_quantizer_to_tuning_table_top
  import pqtt_pkg::*;
#(
  parameter int NOTE_COUNT      = NOTE_COUNT_DEF,
  parameter int CHANNEL_COUNT   = CHANNEL_COUNT_DEF,
  parameter int PITCH_FRAC_BITS = PITCH_FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      opcode,
  input  logic [CHAN_W-1:0]         channel,
  input  logic signed [PITCH_W-1:0] pitch_in,
  input  logic [NOTE_IDX_W-1:0]     note_index,
  input  logic                      note_filtered,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [CHAN_W-1:0]         out_channel,
  output logic signed [PITCH_W-1:0] pitch_out,
  output logic                      changed,
  input  logic                      cfg_write,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  localparam int IDX_W    = $clog2(NOTE_COUNT);
  localparam int SLOT_W   = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int CHAN_SPAN = 1 << CHAN_W;
  localparam int NOTE_SPAN = 1 << NOTE_IDX_W;
  localparam int XW       = 34;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NOTE_COUNT - 1);
  localparam logic signed [XW-1:0] SIXTY_S = XW'(longint'(60) <<< PITCH_FRAC_BITS);
  localparam logic signed [XW-1:0] HALF_S  = XW'(longint'(1) <<< (PITCH_FRAC_BITS - 1));
  localparam logic signed [XW-1:0] ONE_M1  = XW'((longint'(1) <<< PITCH_FRAC_BITS) - 1);
  localparam logic signed [XW-1:0] LAST_S  = XW'(NOTE_COUNT - 1);

  // Sequencer states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]                state;
  logic [1:0]                state_next;
  logic [IDX_W-1:0]          cnt;
  logic                      quant_mode;
  logic [RND_W-1:0]          rounding;
  logic                      table_valid;
  logic signed [PITCH_W-1:0] p_hold;
  logic [CHAN_W-1:0]         chan_hold;
  logic [SLOT_W-1:0]         slot_hold;
  logic [IDX_W-1:0]          sel_idx;
  logic [IDX_W-1:0]          sel_next;
  logic signed [PITCH_W-1:0] last_rd;
  logic                      last_ok;
  logic signed [PITCH_W-1:0] last_mem [CHANNEL_COUNT];
  logic [CHANNEL_COUNT-1:0]  last_seen;
  logic [SLOT_W-1:0]         slot_lut [CHAN_SPAN];
  logic [SLOT_W-1:0]         slot_in;
  logic                      acc;
  logic                      acc_q;
  logic                      out_free;
  logic                      fin_load;
  logic signed [PITCH_W-1:0] scan_res;
  logic signed [PITCH_W-1:0] final_res;
  logic signed [PITCH_W-1:0] prev_out;
  logic signed [XW-1:0]      px;
  logic signed [XW-1:0]      rx;
  logic signed [XW-1:0]      rn;
  logic signed [PITCH_W-1:0] cell_pitch [NOTE_COUNT];
  logic                      cell_filt  [NOTE_COUNT];
  scan_ctl_t                 ctl;

  // Handshake decodes.
  assign in_stall = (state != S_IDLE);
  assign acc      = in_valid && !in_stall;
  assign acc_q    = acc && (opcode == OP_QUANT);
  assign out_free = !out_valid || !out_stall;
  assign fin_load = (state == S_FIN) && out_free;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      quant_mode  <= MODE_SEARCH;
      rounding    <= RND_NEAR;
      table_valid <= 1'b0;
    end else if (cfg_write) begin
      if (cfg_index == REG_QUANT_MODE) begin
        quant_mode <= cfg_data[0];
      end
      if (cfg_index == REG_ROUNDING) begin
        rounding <= cfg_data;
      end
      if (cfg_index == REG_TABLE_VALID) begin
        table_valid <= cfg_data[0];
      end
    end
  end

  // Channel to history slot, folded at elaboration.
  for (genvar c = 0; c < CHAN_SPAN; c++) begin : g_slot
    assign slot_lut[c] = SLOT_W'(c % CHANNEL_COUNT);
  end
  assign slot_in = slot_lut[channel];

  // Retune note number pitch*12+60, rounded and clamped to the table.
  always_comb begin
    px = XW'(pitch_in);
    rx = (px <<< 3) + (px <<< 2) + SIXTY_S;
    if (rounding == RND_DOWN) begin
      rn = rx >>> PITCH_FRAC_BITS;
    end else if (rounding == RND_UP) begin
      rn = (rx + ONE_M1) >>> PITCH_FRAC_BITS;
    end else if (!rx[XW-1]) begin
      rn = (rx + HALF_S) >>> PITCH_FRAC_BITS;
    end else begin
      rn = -((-rx + HALF_S) >>> PITCH_FRAC_BITS);
    end
    if (rn[XW-1]) begin
      sel_next = '0;
    end else if (rn > LAST_S) begin
      sel_next = LAST_IDX;
    end else begin
      sel_next = rn[IDX_W-1:0];
    end
  end

  // Latch the sample of an accepted quantize request.
  always_ff @(posedge clk) begin
    if (acc_q) begin
      p_hold    <= pitch_in;
      chan_hold <= channel;
      slot_hold <= slot_in;
      sel_idx   <= sel_next;
    end
  end

  // Per-channel history; a slot never written reads as zero.
  always_ff @(posedge clk) begin
    if (acc_q) begin
      last_rd <= last_mem[slot_in];
    end
    if (fin_load) begin
      last_mem[slot_hold] <= final_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_seen <= '0;
      last_ok   <= 1'b0;
    end else begin
      if (acc_q) begin
        last_ok <= last_seen[slot_in];
      end
      if (fin_load) begin
        last_seen[slot_hold] <= 1'b1;
      end
    end
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (acc_q) begin
          state_next = table_valid ? S_SCAN : S_FIN;
        end
      end
      S_SCAN: begin
        if (cnt == LAST_IDX) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == S_SCAN) begin
        cnt <= (cnt == LAST_IDX) ? '0 : cnt + IDX_W'(1);
      end
    end
  end

  assign ctl.clear = acc_q;
  assign ctl.step  = (state == S_SCAN);

  // Ring of note cells; cell zero feeds the search unit.
  for (genvar g = 0; g < NOTE_COUNT; g++) begin : g_cell
    localparam int NXT = (g + 1) % NOTE_COUNT;
    localparam bit REACH = (g < NOTE_SPAN);
    localparam logic signed [PITCH_W-1:0] RP = et_pitch(g, PITCH_FRAC_BITS);
    logic wr;

    assign wr = REACH && acc && (opcode == OP_WRITE) && (note_index == NOTE_IDX_W'(g));

    pqtt_cell #(
      .RESET_PITCH(RP)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .wr_en    (wr),
      .wr_pitch (pitch_in),
      .wr_filt  (note_filtered),
      .shift    (ctl.step),
      .nb_pitch (cell_pitch[NXT]),
      .nb_filt  (cell_filt[NXT]),
      .pitch    (cell_pitch[g]),
      .filt     (cell_filt[g])
    );
  end

  pqtt_search #(
    .NOTE_COUNT(NOTE_COUNT)
  ) u_search (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .idx      (cnt),
    .sel      (sel_idx),
    .p        (p_hold),
    .t        (cell_pitch[0]),
    .t_filt   (cell_filt[0]),
    .mode     (quant_mode),
    .rounding (rounding),
    .res      (scan_res)
  );

  assign final_res = table_valid ? scan_res : p_hold;
  assign prev_out  = last_ok ? last_rd : '0;

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      out_channel <= chan_hold;
      pitch_out   <= final_res;
      changed     <= table_valid && (final_res != prev_out);
    end
  end

  // A new result only appears out of the finishing state.
  a_load_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_FIN)
    else $error("result loaded outside the finishing state");

  // Without a table the request skips the scan.
  a_bypass: assert property (@(posedge clk) disable iff (rst)
    (acc_q && !table_valid) |=> state == S_FIN)
    else $error("pass-through request entered the scan");

  // The ring is back at its home position when a scan ends.
  a_ring_home: assert property (@(posedge clk) disable iff (rst)
    $fell(state == S_SCAN) |-> cnt == '0)
    else $error("scan ended away from the home position");

  // A pass-through result never flags a change.
  a_no_change: assert property (@(posedge clk) disable iff (rst)
    (fin_load && !table_valid) |=> !changed)
    else $error("pass-through result flagged as changed");

endmodule
